// ----- design/tsla_pkg.sv -----
// Shared types and character constants for the text stream line annotator.
`default_nettype none
package tsla_pkg;

	// Configuration register indexes
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_NUMBER_NONBLANK  = 3'd0;
	localparam cfg_idx_t CFG_NUMBER_ALL       = 3'd1;
	localparam cfg_idx_t CFG_SHOW_ENDS        = 3'd2;
	localparam cfg_idx_t CFG_SQUEEZE_BLANK    = 3'd3;
	localparam cfg_idx_t CFG_SHOW_TABS        = 3'd4;
	localparam cfg_idx_t CFG_SHOW_NONPRINTING = 3'd5;

	localparam logic [7:0] CHR_TAB      = 8'd9;
	localparam logic [7:0] CHR_NL       = 8'd10;
	localparam logic [7:0] CHR_SPACE    = 8'd32;
	localparam logic [7:0] CHR_DOLLAR   = 8'd36;
	localparam logic [7:0] CHR_ZERO     = 8'd48;
	localparam logic [7:0] CHR_LETTER_I = 8'd73;
	localparam logic [7:0] CHR_CARET    = 8'd94;
	localparam logic [7:0] CHR_TILDE    = 8'd126;
	localparam logic [7:0] CHR_NBSP     = 8'd160;
	localparam logic [7:0] CARET_OFFSET = 8'd64;

	typedef struct packed {
		logic number_nonblank;
		logic number_all;
		logic show_ends;
		logic squeeze_blank;
		logic show_tabs;
		logic show_nonprinting;
	} cfg_t;

	// One classified input byte, as queued between front and back
	typedef struct packed {
		logic       numbered;
		logic       dollar;
		logic       caret;
		logic [7:0] data;
	} cmd_t;

endpackage
`default_nettype wire

// ----- design/text_stream_line_annotator.sv -----
// Top level of the text stream line annotator: config registers, front, queue, back.
//
// Input channel (in_valid/in_ready, data_byte, first_of_file) takes one text byte per
// transaction. Output channel (out_valid/out_ready, out_byte, last_of_run) gives the run
// of bytes that input caused, one per transaction; last_of_run marks the final one.
// A squeezed repeated blank line gives no output at all.
// Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set one mode bit each and
// are taken every cycle; write them only while the block is idle.
// Throughput: one output byte per cycle while out_ready is high and the queue is not
// empty. A plain byte gives 1 byte, a byte that gets a caret or a dollar gives 2, a
// numbered line NUMBER_DIGITS+2 or more; the back end's one-byte-per-cycle output
// register sets the rate. The front takes a new byte every cycle while the two-entry
// queue has room, so input and output stall independently. An accepted input is written
// into the queue; its first output byte then goes from the queue head into the output
// register, which drives out_byte.
// Reset clears all modes, sets the line counter to 1, marks the previous byte as a
// newline and empties the queue. If out_ready stays low the output byte holds, the
// queue fills and in_ready drops.
`default_nettype none
module text_stream_line_annotator #(
	parameter int NUMBER_DIGITS = 6
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire tsla_pkg::cfg_idx_t        cfg_index,
	input  wire logic                      cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [7:0]                data_byte,
	input  wire logic                      first_of_file,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [7:0]                out_byte,
	output logic                           last_of_run
);
	import tsla_pkg::*;

	localparam int BW = 4 * NUMBER_DIGITS;
	localparam int QW = $bits(cmd_t) + BW;

	cfg_t          cfg_q;
	logic          push;
	cmd_t          push_cmd;
	logic [BW-1:0] push_bcd;
	logic          pop;
	logic [QW-1:0] head_data;
	cmd_t          head_cmd;
	logic [BW-1:0] head_bcd;
	logic          q_full;
	logic          q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_data;
				CFG_NUMBER_ALL:       cfg_q.number_all       <= cfg_data;
				CFG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data;
				CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data;
				CFG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data;
				CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data;
				default:              cfg_q                  <= cfg_q;
			endcase
		end
	end

	tsla_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.first_of_file(first_of_file),
		.q_full       (q_full),
		.push         (push),
		.push_cmd     (push_cmd),
		.push_bcd     (push_bcd)
	);

	tsla_fifo #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({push_cmd, push_bcd}),
		.pop   (pop),
		.rdata (head_data),
		.full  (q_full),
		.empty (q_empty)
	);

	assign head_cmd = head_data[QW-1:BW];
	assign head_bcd = head_data[BW-1:0];

	tsla_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head_cmd   (head_cmd),
		.head_bcd   (head_bcd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

	// front never writes a full queue
	ap_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("queue written while full");

	// retiring a queue entry always leaves its final byte in the output register
	ap_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid && last_of_run))
		else $error("entry retired without its final byte");

	// a byte that is not the end of its run belongs to an entry still queued
	ap_mid_run_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_of_run) |-> !q_empty)
		else $error("mid-run byte without a queued entry");

endmodule
`default_nettype wire

// ----- design/tsla_fifo.sv -----
// Small first-in first-out queue between the front and back halves.
`default_nettype none
module tsla_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/tsla_front.sv -----
// Front half: accepts input bytes, tracks line state and classifies each byte.
`default_nettype none
module tsla_front #(
	parameter int NUMBER_DIGITS = 6
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tsla_pkg::cfg_t               cfg,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [7:0]                   data_byte,
	input  wire logic                         first_of_file,
	input  wire logic                         q_full,
	output logic                              push,
	output tsla_pkg::cmd_t                    push_cmd,
	output logic      [4*NUMBER_DIGITS-1:0]   push_bcd
);
	import tsla_pkg::*;

	localparam int BW = 4 * NUMBER_DIGITS;
	localparam logic [BW-1:0] BCD_ONE  = BW'(1);
	localparam logic [BW-1:0] BCD_FULL = {NUMBER_DIGITS{4'd9}};

	function automatic logic [BW-1:0] bcd_inc(input logic [BW-1:0] v);
		logic [BW-1:0] r;
		logic          carry;
		r     = v;
		carry = 1'b1;
		if (v != BCD_FULL) begin
			for (int i = 0; i < NUMBER_DIGITS; i++) begin
				if (carry) begin
					if (r[4*i +: 4] == 4'd9) begin
						r[4*i +: 4] = 4'd0;
					end else begin
						r[4*i +: 4] = r[4*i +: 4] + 4'd1;
						carry = 1'b0;
					end
				end
			end
		end
		return r;
	endfunction

	logic [BW-1:0] bcd_q;
	logic          prev_nl_q;
	logic [1:0]    blank_run_q;

	logic [BW-1:0] bcd_cur;
	logic          prev_nl_cur;
	logic [1:0]    blank_run_cur;
	logic [1:0]    blank_run_nxt;
	logic          is_nl;
	logic          squeeze_hit;
	logic          drop;
	logic          numbered;
	logic          tab_caret;
	logic          np_caret;
	logic [7:0]    data_out;
	logic          accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		bcd_cur       = first_of_file ? BCD_ONE : bcd_q;
		prev_nl_cur   = first_of_file ? 1'b1 : prev_nl_q;
		blank_run_cur = first_of_file ? 2'd0 : blank_run_q;
		is_nl         = (data_byte == CHR_NL);

		squeeze_hit = cfg.squeeze_blank && is_nl && prev_nl_cur;
		if (!squeeze_hit) begin
			blank_run_nxt = 2'd0;
		end else if (blank_run_cur == 2'd2) begin
			blank_run_nxt = 2'd2;
		end else begin
			blank_run_nxt = blank_run_cur + 2'd1;
		end
		drop = squeeze_hit && (blank_run_nxt == 2'd2);

		numbered = prev_nl_cur && (cfg.number_all || (cfg.number_nonblank && !is_nl));

		tab_caret = cfg.show_tabs && (data_byte == CHR_TAB);
		np_caret  = cfg.show_nonprinting && !tab_caret
			&& ((data_byte < CHR_TAB)
			|| (data_byte > CHR_NL && data_byte < CHR_SPACE)
			|| (data_byte > CHR_TILDE && data_byte <= CHR_NBSP));

		if (tab_caret) begin
			data_out = CHR_LETTER_I;
		end else if (np_caret) begin
			data_out = (data_byte < CHR_TILDE) ? data_byte + CARET_OFFSET
				: data_byte - CARET_OFFSET;
		end else begin
			data_out = data_byte;
		end
	end

	assign push              = accept && !drop;
	assign push_cmd.numbered = numbered;
	assign push_cmd.dollar   = cfg.show_ends && is_nl;
	assign push_cmd.caret    = tab_caret || np_caret;
	assign push_cmd.data     = data_out;
	assign push_bcd          = bcd_cur;

	// a translated byte is never a newline, so only the raw byte decides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q       <= BCD_ONE;
			prev_nl_q   <= 1'b1;
			blank_run_q <= 2'd0;
		end else if (accept) begin
			bcd_q       <= (numbered && !drop) ? bcd_inc(bcd_cur) : bcd_cur;
			prev_nl_q   <= is_nl;
			blank_run_q <= blank_run_nxt;
		end
	end

endmodule
`default_nettype wire

// ----- design/tsla_back.sv -----
// Back half: expands each queued command into its run of output bytes.
`default_nettype none
module tsla_back #(
	parameter int NUMBER_DIGITS = 6
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       head_valid,
	input  wire tsla_pkg::cmd_t             head_cmd,
	input  wire logic [4*NUMBER_DIGITS-1:0] head_bcd,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [7:0]                 out_byte,
	output logic                            last_of_run
);
	import tsla_pkg::*;

	// slots: digits, tab, dollar, caret, data byte
	localparam int SW = $clog2(NUMBER_DIGITS + 4);
	localparam logic [SW-1:0] SLOT_TAB    = SW'(NUMBER_DIGITS);
	localparam logic [SW-1:0] SLOT_DOLLAR = SW'(NUMBER_DIGITS + 1);
	localparam logic [SW-1:0] SLOT_CARET  = SW'(NUMBER_DIGITS + 2);
	localparam logic [SW-1:0] SLOT_DATA   = SW'(NUMBER_DIGITS + 3);

	logic [SW-1:0] slot_q;
	logic          fresh_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          last_q;

	logic [SW-1:0] start_slot;
	logic [SW-1:0] cur_slot;
	logic [SW-1:0] next_slot;
	logic [7:0]    digit_chr [NUMBER_DIGITS];
	logic          zero_above;
	logic [7:0]    emit_byte;
	logic          emit;
	logic          emit_last;

	always_comb begin
		if (head_cmd.numbered) begin
			start_slot = '0;
		end else if (head_cmd.dollar) begin
			start_slot = SLOT_DOLLAR;
		end else if (head_cmd.caret) begin
			start_slot = SLOT_CARET;
		end else begin
			start_slot = SLOT_DATA;
		end
		cur_slot = fresh_q ? start_slot : slot_q;

		if (head_cmd.numbered && cur_slot < SLOT_TAB) begin
			next_slot = cur_slot + 1'b1;
		end else if (cur_slot < SLOT_DOLLAR && head_cmd.dollar) begin
			next_slot = SLOT_DOLLAR;
		end else if (cur_slot < SLOT_CARET && head_cmd.caret) begin
			next_slot = SLOT_CARET;
		end else begin
			next_slot = SLOT_DATA;
		end

		// leading zeros print as spaces, the units digit always shows
		zero_above = 1'b1;
		for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
			if (head_bcd[4*i +: 4] == 4'd0 && zero_above && i > 0) begin
				digit_chr[i] = CHR_SPACE;
			end else begin
				digit_chr[i] = CHR_ZERO + {4'd0, head_bcd[4*i +: 4]};
				zero_above   = 1'b0;
			end
		end

		emit_byte = head_cmd.data;
		if (cur_slot < SLOT_TAB) begin
			for (int i = 0; i < NUMBER_DIGITS; i++) begin
				if (cur_slot == SW'(NUMBER_DIGITS - 1 - i)) begin
					emit_byte = digit_chr[i];
				end
			end
		end else begin
			case (cur_slot)
				SLOT_TAB:    emit_byte = CHR_TAB;
				SLOT_DOLLAR: emit_byte = CHR_DOLLAR;
				SLOT_CARET:  emit_byte = CHR_CARET;
				default:     emit_byte = head_cmd.data;
			endcase
		end
	end

	assign emit      = head_valid && (!out_valid_q || out_ready);
	assign emit_last = (cur_slot == SLOT_DATA);
	assign pop       = emit && emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			fresh_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				fresh_q     <= emit_last;
				slot_q      <= next_slot;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			last_q     <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for text_stream_line_annotator: directed table, random text, scoreboard.
`timescale 1ns / 1ps
module tb_top;
	import tsla_pkg::*;

	localparam int DIGITS        = 6;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 1000;
	localparam int DIR_ROWS      = 25;
	localparam int CHUNKS        = 6;
	localparam int CHUNK_ITEMS   = 18;

	localparam cfg_t MODES_PLAIN    = 6'b000000;
	localparam cfg_t MODES_ALL_ON   = 6'b111111;
	localparam cfg_t MODES_NONBLANK = 6'b100000;

	localparam logic [4*DIGITS-1:0] ALL_NINES = {DIGITS{4'h9}};

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_beat_t;

	typedef struct {
		cfg_t       modes;
		logic [7:0] data;
		logic       fof;
		bit         typed;
		string      want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_idx_t cfg_index = CFG_NUMBER_NONBLANK;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'd0;
	logic first_of_file = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_byte;
	logic last_of_run;

	// annotator state as seen by the predictor
	cfg_t modes = MODES_PLAIN;
	logic [4*DIGITS-1:0] line_bcd = 1;
	logic [7:0] prev_byte = CHR_NL;
	logic [1:0] blank_run = 2'd0;

	logic [7:0] predicted_run[$];
	out_beat_t pending_bytes[$];

	int errors = 0;
	int send_idle_pct = 17;
	int recv_idle_pct = 59;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	stim_row_t dir_rows [DIR_ROWS];

	text_stream_line_annotator #(
		.NUMBER_DIGITS(DIGITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.first_of_file(first_of_file),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last_of_run(last_of_run)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Computes the output run of one text byte and advances the line state.
	function automatic void annotate_byte(input logic [7:0] c_in, input logic fof);
		logic [7:0] c;
		logic [3:0] dig;
		logic lead;
		logic carried;
		int i;
		c = c_in;
		predicted_run.delete();
		if (fof) begin
			line_bcd = 1;
			prev_byte = CHR_NL;
			blank_run = 2'd0;
		end
		if (modes.squeeze_blank && c == CHR_NL && prev_byte == CHR_NL) begin
			if (blank_run < 2)
				blank_run++;
			if (blank_run > 1)
				return;
		end else begin
			blank_run = 2'd0;
		end
		if (prev_byte == CHR_NL && (modes.number_all || (modes.number_nonblank && c != CHR_NL))) begin
			lead = 1'b1;
			for (i = DIGITS - 1; i >= 0; i--) begin
				dig = line_bcd[4*i +: 4];
				if (dig == 4'd0 && lead && i > 0) begin
					predicted_run.push_back(CHR_SPACE);
				end else begin
					lead = 1'b0;
					predicted_run.push_back(CHR_ZERO + 8'(dig));
				end
			end
			predicted_run.push_back(CHR_TAB);
			// decimal carry, counter sticks at all nines
			if (line_bcd != ALL_NINES) begin
				carried = 1'b1;
				for (i = 0; i < DIGITS; i++) begin
					if (carried) begin
						if (line_bcd[4*i +: 4] == 4'd9) begin
							line_bcd[4*i +: 4] = 4'd0;
						end else begin
							line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
							carried = 1'b0;
						end
					end
				end
			end
		end
		if (modes.show_ends && c == CHR_NL)
			predicted_run.push_back(CHR_DOLLAR);
		if (modes.show_tabs && c == CHR_TAB) begin
			predicted_run.push_back(CHR_CARET);
			c = CHR_LETTER_I;
		end
		if (modes.show_nonprinting) begin
			if (c < CHR_TAB || (c > CHR_NL && c < CHR_SPACE) || (c > CHR_TILDE && c <= CHR_NBSP)) begin
				predicted_run.push_back(CHR_CARET);
				c = (c < CHR_TILDE) ? c + CARET_OFFSET : c - CARET_OFFSET;
			end
		end
		predicted_run.push_back(c);
		prev_byte = c;
	endfunction

	function automatic void expect_annotated(input logic [7:0] c, input logic fof);
		int i;
		annotate_byte(c, fof);
		for (i = 0; i < predicted_run.size(); i++)
			pending_bytes.push_back('{predicted_run[i], i == predicted_run.size() - 1});
	endfunction

	function automatic logic [7:0] text_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return CHR_NL;
		else if (r < 33)
			return CHR_TAB;
		else if (r < 73)
			return 8'($urandom_range(32, 126));
		else if (r < 85)
			return 8'($urandom_range(0, 31));
		else
			return 8'($urandom_range(127, 255));
	endfunction

	// Returns at the edge where the byte is taken.
	task automatic send_byte(input logic [7:0] d, input logic fof);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		first_of_file <= fof;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		// a squeezed line may still be in flight with nothing expected
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode_bit(input cfg_idx_t idx, input logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic write_modes(input cfg_t m);
		write_mode_bit(CFG_NUMBER_NONBLANK, m.number_nonblank);
		write_mode_bit(CFG_NUMBER_ALL, m.number_all);
		write_mode_bit(CFG_SHOW_ENDS, m.show_ends);
		write_mode_bit(CFG_SQUEEZE_BLANK, m.squeeze_blank);
		write_mode_bit(CFG_SHOW_TABS, m.show_tabs);
		write_mode_bit(CFG_SHOW_NONPRINTING, m.show_nonprinting);
		modes = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// output side backpressure
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected output byte, expected none, actual %h last %b",
					$time, out_byte, last_of_run);
				errors++;
			end else begin
				want = pending_bytes.pop_front();
				if (out_byte !== want.data) begin
					$display("%0t: out_byte mismatch, expected %h, actual %h",
						$time, want.data, out_byte);
					errors++;
				end
				if (last_of_run !== want.last) begin
					$display("%0t: last_of_run mismatch, expected %b, actual %b",
						$time, want.last, last_of_run);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("text_stream_line_annotator test failed");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		logic [7:0] d;
		logic fof;
		int r, i, ch, k;

		dir_rows = '{
			'{MODES_PLAIN,    "A",        1'b0, 1'b1, "A"},
			'{MODES_PLAIN,    8'h00,      1'b0, 1'b0, ""},
			'{MODES_PLAIN,    8'hFF,      1'b0, 1'b0, ""},
			'{MODES_PLAIN,    CHR_TAB,    1'b0, 1'b1, "\t"},
			'{MODES_PLAIN,    CHR_NL,     1'b0, 1'b1, "\n"},
			'{MODES_ALL_ON,   "x",        1'b1, 1'b1, "     1\tx"},
			'{MODES_ALL_ON,   CHR_NL,     1'b0, 1'b1, "$\n"},
			'{MODES_ALL_ON,   CHR_NL,     1'b0, 1'b1, "     2\t$\n"},
			'{MODES_ALL_ON,   CHR_NL,     1'b0, 1'b1, ""},
			'{MODES_ALL_ON,   CHR_TAB,    1'b0, 1'b1, "     3\t^I"},
			'{MODES_ALL_ON,   8'h01,      1'b0, 1'b1, "^A"},
			'{MODES_ALL_ON,   8'h7F,      1'b0, 1'b1, "^?"},
			'{MODES_ALL_ON,   CHR_NBSP,   1'b0, 1'b0, ""},
			'{MODES_ALL_ON,   8'hA1,      1'b0, 1'b0, ""},
			'{MODES_ALL_ON,   CHR_TILDE,  1'b0, 1'b1, "~"},
			'{MODES_ALL_ON,   8'h1F,      1'b0, 1'b1, "^_"},
			'{MODES_ALL_ON,   8'h0B,      1'b0, 1'b1, "^K"},
			'{MODES_ALL_ON,   8'h00,      1'b0, 1'b1, "^@"},
			'{MODES_ALL_ON,   8'hFF,      1'b0, 1'b0, ""},
			'{MODES_ALL_ON,   8'h08,      1'b0, 1'b1, "^H"},
			'{MODES_NONBLANK, CHR_NL,     1'b1, 1'b1, "\n"},
			'{MODES_NONBLANK, "B",        1'b0, 1'b1, "     1\tB"},
			'{MODES_NONBLANK, CHR_NL,     1'b0, 1'b1, "\n"},
			'{MODES_NONBLANK, CHR_NL,     1'b0, 1'b1, "\n"},
			'{MODES_NONBLANK, CHR_TAB,    1'b0, 1'b1, "     2\t\t"}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < DIR_ROWS; r++) begin
			row = dir_rows[r];
			if (row.modes != modes) begin
				drain();
				write_modes(row.modes);
			end
			send_byte(row.data, row.fof);
			if (row.typed) begin
				annotate_byte(row.data, row.fof);
				for (i = 0; i < row.want.len(); i++)
					pending_bytes.push_back('{row.want[i], i == row.want.len() - 1});
			end else begin
				expect_annotated(row.data, row.fof);
			end
		end

		for (ch = 0; ch < CHUNKS; ch++) begin
			drain();
			if (ch == 2) begin
				send_idle_pct = 59;
				recv_idle_pct = 17;
			end else if (ch == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_modes(cfg_t'($urandom_range(0, 63)));
			for (k = 0; k < CHUNK_ITEMS; k++) begin
				d = text_byte();
				fof = ($urandom_range(0, 39) == 0);
				send_byte(d, fof);
				expect_annotated(d, fof);
				// long output stall while input keeps coming: fills the queue
				if (ch == 0 && k == 5)
					hold_cycles = 60;
			end
		end

		drain();
		if (errors == 0)
			$display("text_stream_line_annotator test passed");
		else
			$display("text_stream_line_annotator test failed");
		$finish;
	end

endmodule
